// File: design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and helpers of the fixed-point alu
// operation codes, status codes, queue entry layout and saturation helpers
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH   = 2;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_EQ      = 4'd4,
		OP_NE      = 4'd5,
		OP_LT      = 4'd6,
		OP_LE      = 4'd7,
		OP_GT      = 4'd8,
		OP_GE      = 4'd9,
		OP_MIN     = 4'd10,
		OP_MAX     = 4'd11,
		OP_INC     = 4'd12,
		OP_DEC     = 4'd13,
		OP_TOINT   = 4'd14,
		OP_FROMINT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// classified request as it waits between front and back
	typedef struct packed {
		op_t                op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic        [31:0] ma;
		logic        [31:0] mb;
		logic               neg;
		logic               bzero;
	} entry_t;

	// handshake between the back end and the divider
	typedef struct packed {
		logic busy;
		logic done;
		logic round_up;
	} div_stat_t;

	typedef struct packed {
		logic        [31:0] word;
		logic               ovf;
	} sat_t;

	// saturate a signed value to 32 bits
	function automatic sat_t clamp_sgn(logic signed [63:0] v);
		sat_t r;
		r.ovf = 1'b0;
		r.word = v[31:0];
		if (v > 64'sh7FFF_FFFF) begin
			r.ovf = 1'b1;
			r.word = 32'h7FFF_FFFF;
		end else if (v < -64'sh8000_0000) begin
			r.ovf = 1'b1;
			r.word = 32'h8000_0000;
		end
		return r;
	endfunction

	// apply sign to a magnitude and saturate
	function automatic sat_t clamp_mag(logic [63:0] m, logic neg);
		sat_t r;
		logic [63:0] n;
		n = (~m) + 64'd1;
		r.ovf = 1'b0;
		r.word = neg ? n[31:0] : m[31:0];
		if (neg && m > 64'h8000_0000) begin
			r.ovf = 1'b1;
			r.word = 32'h8000_0000;
		end else if (!neg && m > 64'h7FFF_FFFF) begin
			r.ovf = 1'b1;
			r.word = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

// File: design/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: request classification
// decodes the operation and precomputes operand magnitudes and result sign
// ----------------------------------------------------------------------------
module fpa_front (
	input  logic [3:0]         func,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output fpa_pkg::entry_t    entry
);

	logic [31:0] ma;
	logic [31:0] mb;

	assign ma = operand_a[31] ? (~operand_a) + 32'd1 : operand_a;
	assign mb = operand_b[31] ? (~operand_b) + 32'd1 : operand_b;

	always_comb begin
		entry.op    = fpa_pkg::op_t'(func);
		entry.a     = operand_a;
		entry.b     = operand_b;
		entry.ma    = ma;
		entry.mb    = mb;
		entry.bzero = (operand_b == 32'sd0);
		case (fpa_pkg::op_t'(func))
			fpa_pkg::OP_MUL, fpa_pkg::OP_DIV: entry.neg = operand_a[31] ^ operand_b[31];
			default: entry.neg = operand_a[31];
		endcase
	end

endmodule

// File: design/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue: short request queue
// decouples the front from the back end
// ----------------------------------------------------------------------------
module fpa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpa_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output fpa_pkg::entry_t pop_data
);

	localparam int Depth = fpa_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

	fpa_pkg::entry_t        mem_q [Depth];
	logic [PtrW-1:0]        wr_q;
	logic [PtrW-1:0]        rd_q;
	logic [$clog2(Depth+1)-1:0] cnt_q;

	assign full      = (cnt_q == ($clog2(Depth+1))'(Depth));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + PtrW'(1);
			if (pop)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + PtrW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div: iterative unsigned divider
// restoring division, one quotient bit per cycle, with half-up round bit
// ----------------------------------------------------------------------------
module fpa_div #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [31+FRAC_BITS:0] numer,
	input  logic [31:0]           denom,
	output logic [31+FRAC_BITS:0] quo,
	output fpa_pkg::div_stat_t    stat
);

	localparam int W    = 32 + FRAC_BITS;
	localparam int CntW = $clog2(W + 1);

	logic [W-1:0]    quo_q;
	logic [32:0]     rem_q;
	logic [31:0]     d_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [32:0]     rem_sh;
	logic            fits;

	assign rem_sh = {rem_q[31:0], quo_q[W-1]};
	assign fits   = (rem_sh >= {1'b0, d_q});
	assign quo    = quo_q;

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.round_up = ({rem_q, 1'b0} >= {2'b00, d_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			d_q   <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? rem_sh - {1'b0, d_q} : rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CntW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

// File: design/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: execution back end
// executes one stage, finishes multiply and divide, holds the result register
// ----------------------------------------------------------------------------
module fpa_back #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  fpa_pkg::entry_t    q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_word,
	output logic               compare_true,
	output logic [1:0]         status
);

	localparam int W = 32 + FRAC_BITS;

	logic               s1_valid_q;
	fpa_pkg::op_t       op_s1;
	logic [31:0]        res_s1;
	logic               cmp_s1;
	fpa_pkg::status_t   st_s1;
	logic [63:0]        prod_s1;
	logic               neg_s1;
	logic               divwait_s1;

	logic               out_valid_q;
	logic [31:0]        res_q;
	logic               cmp_q;
	fpa_pkg::status_t   st_q;

	logic               out_free;
	logic               s1_adv;
	logic               s1_load;
	logic               div_start;
	logic [W-1:0]       div_quo;
	fpa_pkg::div_stat_t div_st;

	logic [31:0]        c_res;
	logic               c_cmp;
	fpa_pkg::status_t   c_st;
	logic               c_divwait;
	fpa_pkg::sat_t      c_sat;
	logic signed [63:0] a64;
	logic signed [63:0] b64;
	logic [31:0]        tmag;

	logic [63:0]        mround;
	fpa_pkg::sat_t      f_sat;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_adv    = s1_valid_q && out_free && (!divwait_s1 || div_st.done);
	assign s1_load   = q_valid && (!s1_valid_q || s1_adv);
	assign q_pop     = s1_load;
	assign div_start = s1_load && (q_data.op == fpa_pkg::OP_DIV) && !q_data.bzero;

	fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  ({q_data.ma, {FRAC_BITS{1'b0}}}),
		.denom  (q_data.mb),
		.quo    (div_quo),
		.stat   (div_st)
	);

	// combinational execute of the request at the queue head
	always_comb begin
		a64       = 64'(q_data.a);
		b64       = 64'(q_data.b);
		tmag      = q_data.ma >> FRAC_BITS;
		c_res     = '0;
		c_cmp     = 1'b0;
		c_st      = fpa_pkg::ST_OK;
		c_divwait = 1'b0;
		c_sat     = '0;
		case (q_data.op)
			fpa_pkg::OP_ADD:  c_sat = fpa_pkg::clamp_sgn(a64 + b64);
			fpa_pkg::OP_SUB:  c_sat = fpa_pkg::clamp_sgn(a64 - b64);
			fpa_pkg::OP_INC:  c_sat = fpa_pkg::clamp_sgn(a64 + 64'sd1);
			fpa_pkg::OP_DEC:  c_sat = fpa_pkg::clamp_sgn(a64 - 64'sd1);
			fpa_pkg::OP_FROMINT:
				c_sat = fpa_pkg::clamp_mag({32'd0, q_data.ma} << FRAC_BITS, q_data.neg);
			default: c_sat = '0;
		endcase
		case (q_data.op)
			fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC,
			fpa_pkg::OP_FROMINT: begin
				c_res = c_sat.word;
				c_st  = c_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
			end
			fpa_pkg::OP_DIV: begin
				if (q_data.bzero) c_st = fpa_pkg::ST_DIV0;
				else c_divwait = 1'b1;
			end
			fpa_pkg::OP_EQ:  c_cmp = (q_data.a == q_data.b);
			fpa_pkg::OP_NE:  c_cmp = (q_data.a != q_data.b);
			fpa_pkg::OP_LT:  c_cmp = (q_data.a <  q_data.b);
			fpa_pkg::OP_LE:  c_cmp = (q_data.a <= q_data.b);
			fpa_pkg::OP_GT:  c_cmp = (q_data.a >  q_data.b);
			fpa_pkg::OP_GE:  c_cmp = (q_data.a >= q_data.b);
			fpa_pkg::OP_MIN: c_res = (q_data.a <= q_data.b) ? q_data.a : q_data.b;
			fpa_pkg::OP_MAX: c_res = (q_data.a >= q_data.b) ? q_data.a : q_data.b;
			fpa_pkg::OP_TOINT: c_res = q_data.neg ? (~tmag) + 32'd1 : tmag;
			default: c_res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			op_s1      <= q_data.op;
			res_s1     <= c_res;
			cmp_s1     <= c_cmp;
			st_s1      <= c_st;
			prod_s1    <= 64'(q_data.ma) * 64'(q_data.mb);
			neg_s1     <= q_data.neg;
			divwait_s1 <= c_divwait;
		end
	end

	// finish multiply and divide
	always_comb begin
		mround = prod_s1 + (64'd1 << (FRAC_BITS - 1));
		if (op_s1 == fpa_pkg::OP_MUL)
			f_sat = fpa_pkg::clamp_mag(mround >> FRAC_BITS, neg_s1);
		else
			f_sat = fpa_pkg::clamp_mag(64'(div_quo) + 64'(div_st.round_up), neg_s1);
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cmp_q <= cmp_s1;
			if (op_s1 == fpa_pkg::OP_MUL || divwait_s1) begin
				res_q <= f_sat.word;
				st_q  <= f_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
			end else begin
				res_q <= res_s1;
				st_q  <= st_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_word  = res_q;
	assign compare_true = cmp_q;
	assign status       = st_q;

`ifndef SYNTHESIS
	// a divide never starts while the divider still works on the one before
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy) else $error("divide started while busy");
	// a waiting divide leaves stage one only with a finished quotient
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && divwait_s1) |-> (div_st.done && !div_st.busy))
		else $error("divide left before done");
	// a comparison result never comes with a nonzero status
	a_cmp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && cmp_q) |-> (st_q == fpa_pkg::ST_OK))
		else $error("compare with status");
	// a result that waits is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(res_q)))
		else $error("stalled result changed");
`endif

endmodule

// File: design/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed fixed-point alu on 32-bit raw words
// add, sub, mul, div, compares, min/max, inc/dec and integer conversion
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  input   | in_valid / in_ready   | func, operand_a, operand_b
//  output  | out_valid / out_ready | result_word, compare_true, status
//
//  one request per cycle for every operation but divide while the output is taken; a result
//  is registered in the queue, in the execute stage and in the output register
//  divide holds the execute stage until the bit-serial divider is done
//  multiply is one 32x32 product registered, then rounded on the way to the output
//  a two-entry queue parts the front from the back end, so input keeps
//  flowing for two more requests while a result waits or a divide runs
//  arst_n clears the queue pointers and all valid flags
module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_word,
	output logic               compare_true,
	output logic [1:0]         status
);

	fpa_pkg::entry_t front_entry;
	fpa_pkg::entry_t head_entry;
	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;
	logic            push;

	// request enters the queue whenever there is room
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// decode and operand magnitudes
	fpa_front u_front (
		.func      (func),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.entry     (front_entry)
	);

	fpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (head_entry)
	);

	// execute, finish and hold the result
	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_data       (head_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_word  (result_word),
		.compare_true (compare_true),
		.status       (status)
	);

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the fixed-point alu
// directed corner cases of every operation, then random requests with bursty
// input and a stalling output; results checked in order against a predictor
// ----------------------------------------------------------------------------
module testbench;

	localparam int FB = fpa_pkg::FRAC_BITS_DEF;

	// one expected result
	typedef struct {
		logic [31:0] word;
		logic        cmp;
		logic [1:0]  st;
	} alu_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         func;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] result_word;
	logic               compare_true;
	logic [1:0]         status;

	alu_result_t pending_results[$];
	int          error_count;
	bit          gaps_on;

	fixed_point_alu #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_word(result_word), .compare_true(compare_true), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// saturate a 64-bit value into 32 bits, flag overflow
	function automatic logic [31:0] saturate(longint v, inout logic [1:0] st);
		if (v > 64'sd2147483647) begin
			st = fpa_pkg::ST_OVF;
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			st = fpa_pkg::ST_OVF;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// exact fixed-point arithmetic on 64-bit integers
	function automatic alu_result_t alu_predict(fpa_pkg::op_t op, logic signed [31:0] a_in,
			logic signed [31:0] b_in);
		alu_result_t r;
		longint a, b, p, m, n, d;
		logic [1:0] st;
		a = a_in;
		b = b_in;
		st = fpa_pkg::ST_OK;
		r.word = '0;
		r.cmp = 1'b0;
		case (op)
			fpa_pkg::OP_ADD: r.word = saturate(a + b, st);
			fpa_pkg::OP_SUB: r.word = saturate(a - b, st);
			fpa_pkg::OP_MUL: begin
				p = a * b;
				m = (p < 0) ? -p : p;
				m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
				r.word = saturate((p < 0) ? -m : m, st);
			end
			fpa_pkg::OP_DIV: begin
				if (b == 0) begin
					st = fpa_pkg::ST_DIV0;
				end else begin
					n = ((a < 0) ? -a : a) <<< FB;
					d = (b < 0) ? -b : b;
					m = (2 * n + d) / (2 * d);
					r.word = saturate(((a < 0) != (b < 0)) ? -m : m, st);
				end
			end
			fpa_pkg::OP_EQ: r.cmp = a == b;
			fpa_pkg::OP_NE: r.cmp = a != b;
			fpa_pkg::OP_LT: r.cmp = a < b;
			fpa_pkg::OP_LE: r.cmp = a <= b;
			fpa_pkg::OP_GT: r.cmp = a > b;
			fpa_pkg::OP_GE: r.cmp = a >= b;
			fpa_pkg::OP_MIN: r.word = (a <= b) ? a_in : b_in;
			fpa_pkg::OP_MAX: r.word = (a >= b) ? a_in : b_in;
			fpa_pkg::OP_INC: r.word = saturate(a + 1, st);
			fpa_pkg::OP_DEC: r.word = saturate(a - 1, st);
			fpa_pkg::OP_TOINT: begin
				m = ((a < 0) ? -a : a) >>> FB;
				r.word = 32'((a < 0) ? -m : m);
			end
			default: begin
				m = ((a < 0) ? -a : a) <<< FB;
				r.word = saturate((a < 0) ? -m : m, st);
			end
		endcase
		r.st = st;
		return r;
	endfunction

	// drive one request, hold until accepted; random gap first when enabled
	task automatic send_request(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= op;
		operand_a <= a;
		operand_b <= b;
		pending_results.push_back(alu_predict(op, a, b));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
	endtask

	// pause sending until every expected result has come back
	task automatic drain();
		go_idle();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// random operand biased to boundary values
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
			1: return 32'h8000_0000 + $urandom_range(0, 2);
			2: return $urandom_range(0, 4) - 2;
			3: return $urandom_range(0, 2048) - 1024;
			4: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	// output stall pattern: alternating runs of ready and stall
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if ($urandom_range(0, 2) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	end

	// compare each accepted result against the oldest expectation
	initial begin
		alu_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word=%h", result_word);
					error_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (result_word !== exp_r.word) begin
						$error("result_word expected %h actual %h", exp_r.word, result_word);
						error_count++;
					end
					if (compare_true !== exp_r.cmp) begin
						$error("compare_true expected %b actual %b", exp_r.cmp, compare_true);
						error_count++;
					end
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						error_count++;
					end
				end
			end
		end
	end

	// corners: extremes, overflow both ways, divide by zero, rounding ties
	task automatic test_directed();
		send_request(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
		send_request(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1);
		send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_request(fpa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FFFF);   // tie rounds away
		send_request(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
		send_request(fpa_pkg::OP_DIV, 32'd5, 32'd0);
		send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(fpa_pkg::OP_DIV, 32'h0000_0100, 32'hFFFF_FE00);
		send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(fpa_pkg::OP_EQ, 32'h1234, 32'h1234);
		send_request(fpa_pkg::OP_NE, 32'h1234, 32'h1234);
		send_request(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(fpa_pkg::OP_LE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(fpa_pkg::OP_GT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(fpa_pkg::OP_GE, 32'hFFFF_FFFF, 32'd0);
		send_request(fpa_pkg::OP_MIN, 32'd7, 32'd7);
		send_request(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0);
		send_request(fpa_pkg::OP_TOINT, 32'hFFFF_FE80, 32'h0);          // toward zero
		send_request(fpa_pkg::OP_TOINT, 32'h8000_0000, 32'h0);
		send_request(fpa_pkg::OP_FROMINT, 32'h0080_0000, 32'h0);
		send_request(fpa_pkg::OP_FROMINT, 32'hFF80_0000, 32'h0);
		send_request(fpa_pkg::OP_FROMINT, 32'hFF7F_FFFF, 32'h0);
		drain();
	endtask

	// random requests; inputs flow in bursts, divides kept sparse
	task automatic test_random(int count);
		fpa_pkg::op_t op;
		for (int i = 0; i < count; i++) begin
			op = fpa_pkg::op_t'($urandom_range(0, 15));
			if (op == fpa_pkg::OP_DIV && $urandom_range(0, 2) != 0) op = fpa_pkg::OP_MUL;
			send_request(op, pick_operand(), pick_operand());
			gaps_on = (i % 100) >= 30;   // back-to-back stretch each hundred
			if (i == count / 2) drain();
		end
		go_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = '0;
		operand_a   = '0;
		operand_b   = '0;
		error_count = 0;
		gaps_on     = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog: allow a wide margin for the bit-serial divides
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_queue.sv
design/fpa_div.sv
design/fpa_back.sv
design/fixed_point_alu.sv
tb/testbench.sv
